/* rtl/rhythm_grid_quantizer_swing_assert.svh */
// ----------------------------------------------------------------------------
// rhythm grid quantizer assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RHYTHM_GRID_QUANTIZER_SWING_ASSERT_SVH
`define RHYTHM_GRID_QUANTIZER_SWING_ASSERT_SVH

// same-cycle implication
`define RGQ_ASSERT_IMPLY(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("rhythm grid quantizer check failed");

// implication after a fixed number of cycles
`define RGQ_ASSERT_DELAY(name, cond, n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> ##n (expr)) \
        else $error("rhythm grid quantizer latency check failed");

`endif

/* rtl/rgq_pkg.sv */
// ----------------------------------------------------------------------------
// rgq_pkg
// shared widths, codes, control structs and helpers of the grid quantizer
// ----------------------------------------------------------------------------
package rgq_pkg;

    // fixed field widths
    localparam int RES_BITS       = 8;
    localparam int SPB_BITS       = 24;
    localparam int INTERVAL_BITS  = SPB_BITS + 2;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_RESOLUTION   = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SWING_ENABLE      = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SWING_AMOUNT      = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_QUANTIZE_STRENGTH = 8'd3;

    // operation codes
    localparam logic OP_QUANTIZE   = 1'b0;
    localparam logic OP_SWING_ONLY = 1'b1;

    // reset value of the grid resolution
    localparam logic [RES_BITS-1:0] GRID_RESOLUTION_RESET = 8'd16;

    // control leaving the remainder chain
    typedef struct packed {
        logic valid;
        logic op;
        logic ahead;    // position at or after bar start
        logic q_odd;    // low bit of distance / interval
    } rgq_ctrl_t;

    // static flags derived from configuration
    typedef struct packed {
        logic swing_ok;
        logic res_zero;
    } rgq_flags_t;

    // nonzero multiple of three, by base-four digit sum
    function automatic logic is_triplet(input logic [RES_BITS-1:0] res);
        logic [3:0] digit_sum;
        digit_sum = {2'b00, res[1:0]} + {2'b00, res[3:2]}
                  + {2'b00, res[5:4]} + {2'b00, res[7:6]};
        return (res != '0) && ((digit_sum == 4'd0) || (digit_sum == 4'd3) ||
                               (digit_sum == 4'd6) || (digit_sum == 4'd9) ||
                               (digit_sum == 4'd12));
    endfunction

endpackage

/* rtl/rgq_div_cell.sv */
// ----------------------------------------------------------------------------
// rgq_div_cell
// one restoring division step: shifts one dividend bit into the partial
// remainder, subtracts the divisor when it fits, shifts in the quotient bit
// ----------------------------------------------------------------------------
module rgq_div_cell #(
    parameter int N_BITS    = 26,
    parameter int D_BITS    = 8,
    parameter int SIDE_BITS = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [D_BITS-1:0]    in_rem,
    input  logic [N_BITS-1:0]    in_nq,
    input  logic [D_BITS-1:0]    in_den,
    input  logic [SIDE_BITS-1:0] in_side,
    output logic                 out_valid,
    output logic [D_BITS-1:0]    out_rem,
    output logic [N_BITS-1:0]    out_nq,
    output logic [D_BITS-1:0]    out_den,
    output logic [SIDE_BITS-1:0] out_side
);

    logic [D_BITS+1:0]    diff;
    logic                 fits;
    logic [D_BITS-1:0]    rem_next;
    logic [N_BITS-1:0]    nq_next;
    logic                 valid_reg;
    logic [D_BITS-1:0]    rem_reg;
    logic [N_BITS-1:0]    nq_reg;
    logic [D_BITS-1:0]    den_reg;
    logic [SIDE_BITS-1:0] side_reg;

    // trial subtract of the divisor
    assign diff     = {1'b0, in_rem, in_nq[N_BITS-1]} - {2'b00, in_den};
    assign fits     = ~diff[D_BITS+1];
    assign rem_next = fits ? diff[D_BITS-1:0] : {in_rem[D_BITS-2:0], in_nq[N_BITS-1]};
    assign nq_next  = {in_nq[N_BITS-2:0], fits};

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // payload moves on every cycle
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        nq_reg   <= nq_next;
        den_reg  <= in_den;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_nq    = nq_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

/* rtl/rgq_div_chain.sv */
// ----------------------------------------------------------------------------
// rgq_div_chain
// row of division cells, one quotient bit per cell, one new word per cycle
// ----------------------------------------------------------------------------
module rgq_div_chain #(
    parameter int N_BITS    = 26,
    parameter int D_BITS    = 8,
    parameter int SIDE_BITS = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [N_BITS-1:0]    in_dividend,
    input  logic [D_BITS-1:0]    in_divisor,
    input  logic [SIDE_BITS-1:0] in_side,
    output logic                 out_valid,
    output logic [N_BITS-1:0]    out_quotient,
    output logic [D_BITS-1:0]    out_remainder,
    output logic [D_BITS-1:0]    out_divisor,
    output logic [SIDE_BITS-1:0] out_side
);

    logic                 valid_w [0:N_BITS];
    logic [D_BITS-1:0]    rem_w   [0:N_BITS];
    logic [N_BITS-1:0]    nq_w    [0:N_BITS];
    logic [D_BITS-1:0]    den_w   [0:N_BITS];
    logic [SIDE_BITS-1:0] side_w  [0:N_BITS];

    // head of the row: empty remainder
    assign valid_w[0] = in_valid;
    assign rem_w[0]   = '0;
    assign nq_w[0]    = in_dividend;
    assign den_w[0]   = in_divisor;
    assign side_w[0]  = in_side;

    // one cell per quotient bit
    for (genvar i = 0; i < N_BITS; i++)
    begin : g_cell
        rgq_div_cell #(
            .N_BITS   (N_BITS),
            .D_BITS   (D_BITS),
            .SIDE_BITS(SIDE_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (valid_w[i]),
            .in_rem   (rem_w[i]),
            .in_nq    (nq_w[i]),
            .in_den   (den_w[i]),
            .in_side  (side_w[i]),
            .out_valid(valid_w[i+1]),
            .out_rem  (rem_w[i+1]),
            .out_nq   (nq_w[i+1]),
            .out_den  (den_w[i+1]),
            .out_side (side_w[i+1])
        );
    end

    assign out_valid     = valid_w[N_BITS];
    assign out_quotient  = nq_w[N_BITS];
    assign out_remainder = rem_w[N_BITS];
    assign out_divisor   = den_w[N_BITS];
    assign out_side      = side_w[N_BITS];

endmodule

/* rtl/rgq_post.sv */
// ----------------------------------------------------------------------------
// rgq_post
// four stage tail: nearest point and swing product, swing add and clamp,
// strength product, final saturating add
// ----------------------------------------------------------------------------
module rgq_post
    import rgq_pkg::*;
#(
    parameter int POSITION_BITS = 48,
    parameter int FRACTION_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rgq_ctrl_t                in_ctrl,
    input  logic [INTERVAL_BITS-1:0] in_rem,
    input  logic [INTERVAL_BITS-1:0] in_interval,
    input  logic [POSITION_BITS-1:0] in_pos,
    input  rgq_flags_t               flags,
    input  logic [FRACTION_BITS:0]   swing_amount,
    input  logic [FRACTION_BITS:0]   quantize_strength,
    output logic                     done,
    output logic [POSITION_BITS-1:0] result_position,
    output logic                     passed_through
);

    localparam int IW      = INTERVAL_BITS;
    localparam int F       = FRACTION_BITS;
    localparam int P       = POSITION_BITS;
    localparam int ONE_INT = 1 << FRACTION_BITS;
    localparam int CW      = (POSITION_BITS > INTERVAL_BITS + 2) ? POSITION_BITS
                                                               : INTERVAL_BITS + 2;
    localparam logic [FRACTION_BITS:0] ONE = (FRACTION_BITS + 1)'(ONE_INT);

    // static swing and strength factors
    logic [F:0]   amt_sat;
    logic [F+1:0] amt_x2;
    logic         swing_neg;
    logic [F+1:0] swing_diff;
    logic [F:0]   swing_mag;
    logic [F:0]   str_sat;

    // stage a
    logic [IW-2:0] half;
    logic [IW:0]   sum_up;
    logic          take_rem;
    logic [IW-1:0] mag_a;
    logic          neg_a;
    logic          odd_a;
    logic          apply_next;
    logic [IW+1:0] delta_next;
    logic [IW+F-1:0] swing_prod_next;
    logic          pass_next;

    logic            a_valid_reg;
    logic            a_op_reg;
    logic [P-1:0]    a_pos_reg;
    logic [IW+1:0]   a_delta_reg;
    logic            a_apply_reg;
    logic [IW+F-1:0] a_prod_reg;
    logic            a_pass_reg;

    // stage b
    logic [IW-1:0] off_mag;
    logic [IW+1:0] off_b;
    logic [IW+1:0] add_b;
    logic [IW+1:0] sum_b;
    logic          neg_b;
    logic [IW+1:0] abs_b;
    logic [CW-1:0] pos_b_cw;
    logic [IW:0]   mag_next;
    logic [F:0]    factor_next;

    logic         b_valid_reg;
    logic         b_neg_reg;
    logic [IW:0]  b_mag_reg;
    logic [F:0]   b_factor_reg;
    logic [P-1:0] b_pos_reg;
    logic         b_pass_reg;

    // stage c
    logic              c_valid_reg;
    logic              c_neg_reg;
    logic [IW+F+1:0]   c_prod_reg;
    logic [P-1:0]      c_pos_reg;
    logic              c_pass_reg;

    // stage d
    logic [IW+1:0]  scaled;
    logic [CW-1:0]  scaled_cw;
    logic [CW-1:0]  pos_cw;
    logic [CW-1:0]  room_cw;
    logic [P-1:0]   result_next;
    logic           done_reg;
    logic [P-1:0]   result_reg;
    logic           passed_reg;

    // saturate factors at one, signed swing ratio 2a - one
    always_comb
    begin
        amt_sat    = (swing_amount > ONE) ? ONE : swing_amount;
        amt_x2     = {amt_sat, 1'b0};
        swing_neg  = amt_x2 < {1'b0, ONE};
        swing_diff = swing_neg ? ({1'b0, ONE} - amt_x2) : (amt_x2 - {1'b0, ONE});
        swing_mag  = swing_diff[F:0];
        str_sat    = (quantize_strength > ONE) ? ONE : quantize_strength;
    end

    // nearest grid point from remainder and direction
    always_comb
    begin
        half     = in_interval[IW-1:1];
        sum_up   = {1'b0, in_rem} + {2'b00, half};
        take_rem = in_ctrl.ahead ? (sum_up < {1'b0, in_interval})
                                 : (in_rem <= {1'b0, half});
        mag_a    = take_rem ? in_rem : (in_interval - in_rem);
        neg_a    = (in_ctrl.ahead == take_rem);
        odd_a    = take_rem ? in_ctrl.q_odd : ~in_ctrl.q_odd;
        if (in_ctrl.op == OP_QUANTIZE)
        begin
            apply_next = flags.swing_ok & odd_a;
        end
        else
        begin
            apply_next = flags.swing_ok & in_ctrl.ahead & in_ctrl.q_odd;
        end
        delta_next      = neg_a ? (~{2'b00, mag_a} + 1'b1) : {2'b00, mag_a};
        swing_prod_next = (IW + F)'(half) * (IW + F)'(swing_mag);
        pass_next       = (in_interval == '0) | flags.res_zero;
    end

    // stage a registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_op_reg    <= in_ctrl.op;
        a_pos_reg   <= in_pos;
        a_delta_reg <= delta_next;
        a_apply_reg <= apply_next;
        a_prod_reg  <= swing_prod_next;
        a_pass_reg  <= pass_next;
    end

    // swing offset, added to the grid offset in quantize mode, clamp so the target stays at or above zero
    always_comb
    begin
        off_mag  = a_prod_reg[IW+F-1:F];
        off_b    = swing_neg ? (~{2'b00, off_mag} + 1'b1) : {2'b00, off_mag};
        add_b    = a_apply_reg ? off_b : '0;
        sum_b    = (a_op_reg == OP_QUANTIZE) ? (a_delta_reg + add_b) : add_b;
        neg_b    = sum_b[IW+1];
        abs_b    = neg_b ? (~sum_b + 1'b1) : sum_b;
        pos_b_cw = CW'(a_pos_reg);
        if (neg_b && (CW'(abs_b) > pos_b_cw))
        begin
            mag_next = pos_b_cw[IW:0];
        end
        else
        begin
            mag_next = abs_b[IW:0];
        end
        factor_next = (a_op_reg == OP_QUANTIZE) ? str_sat : ONE;
    end

    // stage b registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_neg_reg    <= neg_b;
        b_mag_reg    <= mag_next;
        b_factor_reg <= factor_next;
        b_pos_reg    <= a_pos_reg;
        b_pass_reg   <= a_pass_reg;
    end

    // strength product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_neg_reg  <= b_neg_reg;
        c_prod_reg <= (IW + F + 2)'(b_mag_reg) * (IW + F + 2)'(b_factor_reg);
        c_pos_reg  <= b_pos_reg;
        c_pass_reg <= b_pass_reg;
    end

    // final add, clamped at zero and saturated at the top
    always_comb
    begin
        scaled    = c_prod_reg[IW+F+1:F];
        scaled_cw = CW'(scaled);
        pos_cw    = CW'(c_pos_reg);
        room_cw   = CW'(~c_pos_reg);
        if (c_pass_reg)
        begin
            result_next = c_pos_reg;
        end
        else if (c_neg_reg)
        begin
            result_next = (scaled_cw > pos_cw) ? '0 : (c_pos_reg - scaled_cw[P-1:0]);
        end
        else
        begin
            result_next = (scaled_cw > room_cw) ? '1 : (c_pos_reg + scaled_cw[P-1:0]);
        end
    end

    // output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        passed_reg <= c_pass_reg;
    end

    assign done            = done_reg;
    assign result_position = result_reg;
    assign passed_through  = passed_reg;

endmodule

/* rtl/rhythm_grid_quantizer_swing.sv */
// ----------------------------------------------------------------------------
// rhythm_grid_quantizer_swing
// snaps note positions to a rhythm grid with swing and strength
// ----------------------------------------------------------------------------
//  channel   signals                                        handshake
//  input     start, busy, op, sample_position,              start && !busy
//            samples_per_beat, bar_start
//  result    done, result_position, passed_through          done, one cycle
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data      cfg_valid && cfg_ready
//
//  one word is taken per cycle; each result passes an input register, two
//  division cell rows (26 cells for the grid interval and one cell per
//  position bit for the distance remainder) and the tail stages. busy
//  drops and cfg_ready rises in the cycle after reset is released; after
//  that busy stays low. results cannot be stalled.
// ----------------------------------------------------------------------------
`include "rhythm_grid_quantizer_swing_assert.svh"

module rhythm_grid_quantizer_swing
    import rgq_pkg::*;
#(
    parameter int POSITION_BITS = 48,
    parameter int FRACTION_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      op,
    input  logic [POSITION_BITS-1:0]  sample_position,
    input  logic [SPB_BITS-1:0]       samples_per_beat,
    input  logic [POSITION_BITS-1:0]  bar_start,
    output logic                      done,
    output logic [POSITION_BITS-1:0]  result_position,
    output logic                      passed_through,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int P        = POSITION_BITS;
    localparam int F        = FRACTION_BITS;
    localparam int ONE_INT  = 1 << FRACTION_BITS;
    localparam int LATENCY  = 1 + INTERVAL_BITS + POSITION_BITS + 4;
    localparam int SIDE1    = 2 * POSITION_BITS + 2;
    localparam int SIDE2    = POSITION_BITS + 2;
    localparam logic [FRACTION_BITS:0] AMOUNT_RESET =
        (FRACTION_BITS + 1)'((ONE_INT < 128) ? ONE_INT : 128);
    localparam logic [FRACTION_BITS:0] STRENGTH_RESET =
        (FRACTION_BITS + 1)'((ONE_INT < 256) ? ONE_INT : 256);

    logic ready_reg;
    logic accept;

    logic [RES_BITS-1:0] grid_resolution_reg;
    logic                swing_enable_reg;
    logic [F:0]          swing_amount_reg;
    logic [F:0]          quantize_strength_reg;

    logic                s0_valid_reg;
    logic                s0_op_reg;
    logic [P-1:0]        s0_pos_reg;
    logic [P-1:0]        s0_dist_reg;
    logic                s0_ahead_reg;
    logic [SPB_BITS-1:0] s0_spb_reg;
    logic                ahead_next;
    logic [P-1:0]        dist_next;

    logic                     d1_valid;
    logic [INTERVAL_BITS-1:0] d1_interval;
    logic [SIDE1-1:0]         d1_side;

    logic                     d2_valid;
    logic [P-1:0]             d2_quotient;
    logic [INTERVAL_BITS-1:0] d2_rem;
    logic [INTERVAL_BITS-1:0] d2_interval;
    logic [SIDE2-1:0]         d2_side;

    rgq_ctrl_t  post_ctrl;
    rgq_flags_t flags;

    // ready after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
        end
        else
        begin
            ready_reg <= 1'b1;
        end
    end

    assign busy      = ~ready_reg;
    assign cfg_ready = ready_reg;
    assign accept    = start & ~busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_resolution_reg   <= GRID_RESOLUTION_RESET;
            swing_enable_reg      <= 1'b0;
            swing_amount_reg      <= AMOUNT_RESET;
            quantize_strength_reg <= STRENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GRID_RESOLUTION:   grid_resolution_reg   <= cfg_data[RES_BITS-1:0];
                REG_SWING_ENABLE:      swing_enable_reg      <= cfg_data[0];
                REG_SWING_AMOUNT:      swing_amount_reg      <= cfg_data[F:0];
                REG_QUANTIZE_STRENGTH: quantize_strength_reg <= cfg_data[F:0];
                default: ;
            endcase
        end
    end

    // static flags from configuration
    assign flags.swing_ok = swing_enable_reg & (swing_amount_reg != '0)
                          & ~is_triplet(grid_resolution_reg);
    assign flags.res_zero = (grid_resolution_reg == '0);

    // distance from bar start as direction and magnitude
    assign ahead_next = sample_position >= bar_start;
    assign dist_next  = ahead_next ? (sample_position - bar_start)
                                   : (bar_start - sample_position);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_op_reg    <= op;
            s0_pos_reg   <= sample_position;
            s0_dist_reg  <= dist_next;
            s0_ahead_reg <= ahead_next;
            s0_spb_reg   <= samples_per_beat;
        end
    end

    // grid interval: four beats over the resolution
    rgq_div_chain #(
        .N_BITS   (INTERVAL_BITS),
        .D_BITS   (RES_BITS),
        .SIDE_BITS(SIDE1)
    ) u_interval_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s0_valid_reg),
        .in_dividend  ({s0_spb_reg, 2'b00}),
        .in_divisor   (grid_resolution_reg),
        .in_side      ({s0_op_reg, s0_pos_reg, s0_dist_reg, s0_ahead_reg}),
        .out_valid    (d1_valid),
        .out_quotient (d1_interval),
        .out_remainder(),
        .out_divisor  (),
        .out_side     (d1_side)
    );

    // distance over interval: remainder and cell parity
    rgq_div_chain #(
        .N_BITS   (POSITION_BITS),
        .D_BITS   (INTERVAL_BITS),
        .SIDE_BITS(SIDE2)
    ) u_distance_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (d1_valid),
        .in_dividend  (d1_side[P:1]),
        .in_divisor   (d1_interval),
        .in_side      ({d1_side[SIDE1-1], d1_side[SIDE1-2:P+1], d1_side[0]}),
        .out_valid    (d2_valid),
        .out_quotient (d2_quotient),
        .out_remainder(d2_rem),
        .out_divisor  (d2_interval),
        .out_side     (d2_side)
    );

    assign post_ctrl.valid = d2_valid;
    assign post_ctrl.op    = d2_side[SIDE2-1];
    assign post_ctrl.ahead = d2_side[0];
    assign post_ctrl.q_odd = d2_quotient[0];

    // target, swing, strength and saturation
    rgq_post #(
        .POSITION_BITS(POSITION_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_post (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_ctrl          (post_ctrl),
        .in_rem           (d2_rem),
        .in_interval      (d2_interval),
        .in_pos           (d2_side[P:1]),
        .flags            (flags),
        .swing_amount     (swing_amount_reg),
        .quantize_strength(quantize_strength_reg),
        .done             (done),
        .result_position  (result_position),
        .passed_through   (passed_through)
    );

    // every accepted word comes out after the fixed latency
    `RGQ_ASSERT_DELAY(a_latency, accept, LATENCY, done)
    // a passed word returns its own position
    `RGQ_ASSERT_IMPLY(a_pass_value, done && passed_through,
                      result_position == $past(sample_position, LATENCY))
    // zero resolution always passes through
    `RGQ_ASSERT_IMPLY(a_zero_res, done && (grid_resolution_reg == '0), passed_through)

endmodule
